FILE: hdl/sorted_list_insert_delete_top_macros.svh
// Assertion helpers for the sorted store.
`ifndef SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sli_pkg.sv
package sli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_RANGE     = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic [3:0]         index;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         count;
  } res_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic signed [31:0] entry;
    logic               valid;
    logic               less;  // valid entry below the broadcast value
    logic               hit;   // match here or in any cell to the left
  } cell_link_t;

endpackage

FILE: hdl/sli_cell.sv
module sli_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sli_pkg::cell_cmd_t    cmd_i,
  input  sli_pkg::cell_link_t   left_i,
  input  sli_pkg::cell_link_t   right_i,
  output sli_pkg::cell_link_t   cell_o
);

  logic signed [31:0] entry_q, entry_d;
  logic               valid_q, valid_d;
  logic               less, match, hit;

  assign less  = valid_q && ($signed(entry_q) < $signed(cmd_i.value));
  assign match = valid_q && (entry_q == cmd_i.value);
  assign hit   = left_i.hit | match;

  assign cell_o.entry = entry_q;
  assign cell_o.valid = valid_q;
  assign cell_o.less  = less;
  assign cell_o.hit   = hit;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      // take the new value at the boundary, shift right beyond it
      if (!less) begin
        entry_d = left_i.less ? cmd_i.value : left_i.entry;
      end
      valid_d = valid_q | left_i.valid;
    end else if (cmd_i.del && hit) begin
      // close the gap: pull from the right neighbour
      entry_d = right_i.entry;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: hdl/sorted_list_insert_delete_top.sv
// Sorted store of signed 32-bit values, held in a row of cells in ascending order.
// Command channel: present a beat on in_i with start_i high; it is taken at a
// rising edge where busy_o is low. busy_o stays low, so a command may be issued
// in every cycle.
// Operations: insert places the value ahead of the first entry not smaller;
// delete removes the first equal entry; read returns the entry at a position
// (op code 3 reads as well).
// Result channel: exactly one result beat per command, on res_o with done_o
// high for a single cycle, in the cycle after the command is taken. The receiver
// cannot hold results off, so it must take every beat as it comes.
// Throughput is one command per cycle: every cell compares its entry with the
// broadcast value and shifts to or from a neighbour in that same cycle; the
// match ripple along the row sets the critical path.
// Reset empties the store at once (count zero); no clearing pass is needed.
// Status codes: inserted, deleted, not found, full, read ok, out of range.
module sorted_list_insert_delete_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  sli_pkg::in_t   in_i,
  output logic           done_o,
  output sli_pkg::res_t  res_o
);

  localparam int unsigned Cap = sli_pkg::CAPACITY;

  logic                          accept;
  logic [sli_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          done_q;
  sli_pkg::res_t                 res_q, res_d;
  sli_pkg::cell_cmd_t            cmd;
  sli_pkg::cell_link_t           cell_out [Cap];
  sli_pkg::cell_link_t           left_in  [Cap];
  sli_pkg::cell_link_t           right_in [Cap];
  logic                          full, found, in_range;
  logic signed [31:0]            rd_value;
  logic [Cap-1:0]                valid_vec;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == sli_pkg::CNT_W'(Cap));
  assign found  = cell_out[Cap-1].hit;

  always_comb begin
    cmd.value = in_i.value;
    cmd.ins   = accept && (sli_pkg::op_e'(in_i.op) == sli_pkg::OP_INSERT) && !full;
    cmd.del   = accept && (sli_pkg::op_e'(in_i.op) == sli_pkg::OP_DELETE);
  end

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '{entry: '0, valid: 1'b1, less: 1'b1, hit: 1'b0};
    end else begin : g_mid_l
      assign left_in[g] = cell_out[g-1];
    end
    if (g == Cap - 1) begin : g_last
      assign right_in[g] = '{entry: '0, valid: 1'b0, less: 1'b0, hit: 1'b0};
    end else begin : g_mid_r
      assign right_in[g] = cell_out[g+1];
    end

    sli_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_in[g]),
      .right_i (right_in[g]),
      .cell_o  (cell_out[g])
    );

    assign valid_vec[g] = cell_out[g].valid;
  end

  // Read port: select the cell at the requested position.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < Cap; i++) begin
      if (32'(in_i.index) == 32'(i)) begin
        rd_value = cell_out[i].entry;
      end
    end
  end

  assign in_range = (32'(in_i.index) < 32'(count_q));

  always_comb begin
    count_d          = count_q;
    res_d.read_value = '0;
    unique case (sli_pkg::op_e'(in_i.op))
      sli_pkg::OP_INSERT: begin
        if (full) begin
          res_d.status = sli_pkg::ST_FULL;
        end else begin
          res_d.status = sli_pkg::ST_INSERTED;
          count_d      = count_q + 1'b1;
        end
      end
      sli_pkg::OP_DELETE: begin
        if (found) begin
          res_d.status = sli_pkg::ST_DELETED;
          count_d      = count_q - 1'b1;
        end else begin
          res_d.status = sli_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (in_range) begin
          res_d.status     = sli_pkg::ST_READ_OK;
          res_d.read_value = rd_value;
        end else begin
          res_d.status = sli_pkg::ST_RANGE;
        end
      end
    endcase
    res_d.count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result beat until the next accepted command.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`include "sorted_list_insert_delete_top_macros.svh"

  `SLI_ASSERT_ALWAYS(a_count_bound, count_q <= sli_pkg::CNT_W'(Cap), "count beyond capacity")
  `SLI_ASSERT_ALWAYS(a_valid_count, $countones(valid_vec) == 32'(count_q), "valid bits vs count")
  `SLI_ASSERT_NEXT(a_done_follows, accept, done_o, "accepted command gave no result beat")
  `SLI_ASSERT_NEXT(a_no_spurious, !accept, !done_o, "result beat without a command")

endmodule
